// File: rtl/sgfa_pkg.sv
package sgfa_pkg;

  // Width of the flattened gridbox index on the input channel
  localparam int IDX_BITS = 30;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd2;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Item operation
  typedef enum logic {
    OP_LOOKUP  = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    op_t                 op;
    logic [IDX_BITS-1:0] idx;
  } item_t;

  // Back-end sequencer states
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MUL1  = 10'b0000000010,
    ST_MUL2  = 10'b0000000100,
    ST_CHECK = 10'b0000001000,
    ST_DIV1  = 10'b0000010000,
    ST_DIV2  = 10'b0000100000,
    ST_MUL3  = 10'b0001000000,
    ST_SUM   = 10'b0010000000,
    ST_ADDR  = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

endpackage

// File: rtl/sgfa_front.sv
module sgfa_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [sgfa_pkg::IDX_BITS-1:0]    in_box_index,
  output logic                             q_valid,
  output sgfa_pkg::item_t                  q_item,
  input  logic                             q_pop
);

  sgfa_pkg::item_t                 mem_r [sgfa_pkg::QDEPTH];
  logic [sgfa_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [sgfa_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [sgfa_pkg::QCNT_W-1:0]     cnt_r;
  logic [sgfa_pkg::QCNT_W-1:0]     cnt_nxt;
  logic                            push;
  logic                            pop;
  sgfa_pkg::item_t                 item_in;

  // Classify the incoming item
  always_comb begin
    item_in.op  = in_kind ? sgfa_pkg::OP_ADVANCE : sgfa_pkg::OP_LOOKUP;
    item_in.idx = in_box_index;
  end

  assign in_stall = (cnt_r == sgfa_pkg::QCNT_W'(sgfa_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + sgfa_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - sgfa_pkg::QCNT_W'(1);
    end
  end

  // Advance pointers and count; the depth is a power of two so pointers wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + sgfa_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + sgfa_pkg::QPTR_W'(1);
      end
    end
  end

  // Store the transfer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// File: rtl/sgfa_div.sv
module sgfa_div #(
  parameter int DIM_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sgfa_pkg::IDX_BITS-1:0] dividend,
  input  logic [DIM_BITS-1:0]           divisor,
  output logic                          done,
  output logic [sgfa_pkg::IDX_BITS-1:0] quotient,
  output logic [DIM_BITS-1:0]           remainder
);

  localparam int IW    = sgfa_pkg::IDX_BITS;
  localparam int CNT_W = $clog2(IW + 1);

  logic [IW-1:0]       quo_r;
  logic [DIM_BITS-1:0] rem_r;
  logic [DIM_BITS-1:0] dvs_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DIM_BITS:0]   trial;
  logic [DIM_BITS:0]   diff;
  logic                ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[IW-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(IW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[IW-2:0], ge};
      rem_r <= ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: rtl/sgfa_back.sv
module sgfa_back #(
  parameter int DIM_BITS  = 10,
  parameter int ADDR_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  sgfa_pkg::item_t       q_item,
  output logic                  q_pop,
  input  logic [DIM_BITS-1:0]   cells_z,
  input  logic [DIM_BITS-1:0]   cells_x,
  input  logic [DIM_BITS-1:0]   cells_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIM_BITS-1:0]   out_coord_k,
  output logic [DIM_BITS-1:0]   out_coord_i,
  output logic [DIM_BITS-1:0]   out_coord_j,
  output logic [ADDR_BITS-1:0]  out_lower_face_addr,
  output logic [ADDR_BITS-1:0]  out_upper_face_addr,
  output logic                  out_out_of_range
);

  localparam int IW     = sgfa_pkg::IDX_BITS;
  localparam int NZF_W  = DIM_BITS + 1;
  localparam int ZX_W   = 2 * DIM_BITS;
  localparam int FZX_W  = 2 * DIM_BITS + 1;
  localparam int TOT_W  = 3 * DIM_BITS;
  localparam int BASE_W = 3 * DIM_BITS + 1;
  localparam int CMP_W  = (TOT_W > IW) ? TOT_W : IW;
  localparam int SUM_W  = ((BASE_W > ADDR_BITS) ? BASE_W : ADDR_BITS) + 1;
  localparam logic [ADDR_BITS-1:0] ADDR_MAX = {ADDR_BITS{1'b1}};

  sgfa_pkg::state_t      state_r;
  sgfa_pkg::state_t      state_nxt;
  sgfa_pkg::op_t         op_r;
  logic [IW-1:0]         idx_r;
  logic [NZF_W-1:0]      nzf;
  logic [ZX_W-1:0]       zx_r;
  logic [FZX_W-1:0]      fzx_r;
  logic [TOT_W-1:0]      total_r;
  logic [BASE_W-1:0]     fstep_r;
  logic [DIM_BITS-1:0]   k_r;
  logic [DIM_BITS-1:0]   i_r;
  logic [DIM_BITS-1:0]   j_r;
  logic [BASE_W-1:0]     prod_a_r;
  logic [FZX_W-1:0]      prod_b_r;
  logic [BASE_W-1:0]     base_r;
  logic [ADDR_BITS-1:0]  offset_r;
  logic [ADDR_BITS-1:0]  res_lo_r;
  logic                  res_flag_r;
  logic                  addr_ok_r;
  logic                  out_valid_r;
  logic [DIM_BITS-1:0]   out_k_r;
  logic [DIM_BITS-1:0]   out_i_r;
  logic [DIM_BITS-1:0]   out_j_r;
  logic [ADDR_BITS-1:0]  out_lo_r;
  logic [ADDR_BITS-1:0]  out_up_r;
  logic                  out_flag_r;

  logic                  slot_free;
  logic                  beyond;
  logic [SUM_W-1:0]      add_b;
  logic [SUM_W-1:0]      add_sum;
  logic                  add_sat;
  logic [ADDR_BITS-1:0]  add_res;
  logic                  lo_top;
  logic [ADDR_BITS-1:0]  up_val;
  logic                  up_flag;

  logic                  div_start;
  logic [IW-1:0]         div_dividend;
  logic [DIM_BITS-1:0]   div_divisor;
  logic                  div_done;
  logic [IW-1:0]         div_quo;
  logic [DIM_BITS-1:0]   div_rem;

  // Shared serial divider: first idx / cells_z, then quotient / cells_x
  sgfa_div #(
    .DIM_BITS (DIM_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign nzf       = NZF_W'(cells_z) + NZF_W'(1);
  assign slot_free = !out_valid_r || !out_stall;
  assign beyond    = (CMP_W'(idx_r) >= CMP_W'(total_r));
  assign q_pop     = (state_r == sgfa_pkg::ST_IDLE) && q_valid;

  // Launch a division when a lookup passes the range check or the first one ends
  always_comb begin
    div_start    = 1'b0;
    div_dividend = idx_r;
    div_divisor  = cells_z;
    if (state_r == sgfa_pkg::ST_CHECK) begin
      div_start = (op_r == sgfa_pkg::OP_LOOKUP) && !beyond;
    end else if (state_r == sgfa_pkg::ST_DIV1) begin
      div_start    = div_done;
      div_dividend = div_quo;
      div_divisor  = cells_x;
    end
  end

  // Saturating adder shared by the offset advance and the face address
  always_comb begin
    add_b   = (op_r == sgfa_pkg::OP_ADVANCE) ? SUM_W'(fstep_r) : SUM_W'(base_r);
    add_sum = SUM_W'(offset_r) + add_b;
    add_sat = |add_sum[SUM_W-1:ADDR_BITS];
    add_res = add_sat ? ADDR_MAX : add_sum[ADDR_BITS-1:0];
  end

  // For a computed address the upper face is lower plus one, saturating at the top; otherwise it is zero
  always_comb begin
    lo_top  = (res_lo_r == ADDR_MAX);
    up_val  = '0;
    if (addr_ok_r) begin
      up_val = lo_top ? ADDR_MAX : res_lo_r + ADDR_BITS'(1);
    end
    up_flag = res_flag_r || (addr_ok_r && lo_top);
  end

  // Sequence one item at a time
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgfa_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = sgfa_pkg::ST_MUL1;
        end
      end
      sgfa_pkg::ST_MUL1:  state_nxt = sgfa_pkg::ST_MUL2;
      sgfa_pkg::ST_MUL2:  state_nxt = sgfa_pkg::ST_CHECK;
      sgfa_pkg::ST_CHECK: begin
        if (op_r == sgfa_pkg::OP_LOOKUP && !beyond) begin
          state_nxt = sgfa_pkg::ST_DIV1;
        end else begin
          state_nxt = sgfa_pkg::ST_DONE;
        end
      end
      sgfa_pkg::ST_DIV1: begin
        if (div_done) begin
          state_nxt = sgfa_pkg::ST_DIV2;
        end
      end
      sgfa_pkg::ST_DIV2: begin
        if (div_done) begin
          state_nxt = sgfa_pkg::ST_MUL3;
        end
      end
      sgfa_pkg::ST_MUL3: state_nxt = sgfa_pkg::ST_SUM;
      sgfa_pkg::ST_SUM:  state_nxt = sgfa_pkg::ST_ADDR;
      sgfa_pkg::ST_ADDR: state_nxt = sgfa_pkg::ST_DONE;
      sgfa_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = sgfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sgfa_pkg::ST_IDLE;
    endcase
  end

  // Control state: sequencer, time-slice offset, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgfa_pkg::ST_IDLE;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sgfa_pkg::ST_CHECK && op_r == sgfa_pkg::OP_ADVANCE) begin
        offset_r <= add_res;
      end
      if (state_r == sgfa_pkg::ST_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      sgfa_pkg::ST_IDLE: begin
        op_r  <= q_item.op;
        idx_r <= q_item.idx;
      end
      sgfa_pkg::ST_MUL1: begin
        zx_r  <= ZX_W'(cells_z) * ZX_W'(cells_x);
        fzx_r <= FZX_W'(nzf) * FZX_W'(cells_x);
      end
      sgfa_pkg::ST_MUL2: begin
        total_r <= TOT_W'(zx_r) * TOT_W'(cells_y);
        fstep_r <= BASE_W'(fzx_r) * BASE_W'(cells_y);
      end
      sgfa_pkg::ST_CHECK: begin
        k_r        <= '0;
        i_r        <= '0;
        j_r        <= '0;
        res_lo_r   <= '0;
        addr_ok_r  <= 1'b0;
        res_flag_r <= (op_r == sgfa_pkg::OP_ADVANCE) ? add_sat : beyond;
      end
      sgfa_pkg::ST_DIV1: begin
        if (div_done) begin
          k_r <= div_rem;
        end
      end
      sgfa_pkg::ST_DIV2: begin
        if (div_done) begin
          i_r <= div_rem;
          j_r <= div_quo[DIM_BITS-1:0];
        end
      end
      sgfa_pkg::ST_MUL3: begin
        prod_a_r <= BASE_W'(fzx_r) * BASE_W'(j_r);
        prod_b_r <= FZX_W'(nzf) * FZX_W'(i_r);
      end
      sgfa_pkg::ST_SUM: begin
        base_r <= prod_a_r + BASE_W'(prod_b_r) + BASE_W'(k_r);
      end
      sgfa_pkg::ST_ADDR: begin
        res_lo_r   <= add_res;
        res_flag_r <= add_sat;
        addr_ok_r  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Load the output register when it is free
  always_ff @(posedge clk) begin
    if (state_r == sgfa_pkg::ST_DONE && slot_free) begin
      out_k_r    <= k_r;
      out_i_r    <= i_r;
      out_j_r    <= j_r;
      out_lo_r   <= res_lo_r;
      out_up_r   <= up_val;
      out_flag_r <= up_flag;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_coord_k         = out_k_r;
  assign out_coord_i         = out_i_r;
  assign out_coord_j         = out_j_r;
  assign out_lower_face_addr = out_lo_r;
  assign out_upper_face_addr = out_up_r;
  assign out_out_of_range    = out_flag_r;

endmodule

// File: rtl/staggered_grid_face_address.sv
// Face address generator for a flattened 3-D grid with z-face storage.
// Input channel (in_valid/in_stall): in_kind 0 looks up gridbox in_box_index
// and returns its (k,i,j) and the lower/upper z-face addresses offset by the
// current time slice; in_kind 1 advances the slice offset by one face array.
// Result channel (out_valid/out_stall): exactly one result per item, in order.
// Config channel (cfg_valid/cfg_ready): cfg_index 0..2 writes cells_z,
// cells_x, cells_y; other indexes are ignored. cfg_ready is always high.
// A lookup in range runs two 30-step bit-serial divisions in one shared
// divider; an advance or an out-of-range lookup skips them. Items are
// processed one at a time: the back end takes the next item only after the
// last result has been loaded into the output register.
// A two-entry queue keeps taking items while the back end is busy, and the
// back end keeps working while a result waits in the output register; when
// the receiver stalls, the finished result holds and the sequencer waits.
// Reset (rst_n low, synchronous) sets all sizes to 1, the slice offset to 0,
// and empties the queue and output register.
module staggered_grid_face_address #(
  parameter int DIM_BITS  = 10,
  parameter int ADDR_BITS = 40
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [sgfa_pkg::IDX_BITS-1:0]       in_box_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [DIM_BITS-1:0]                 out_coord_k,
  output logic [DIM_BITS-1:0]                 out_coord_i,
  output logic [DIM_BITS-1:0]                 out_coord_j,
  output logic [ADDR_BITS-1:0]                out_lower_face_addr,
  output logic [ADDR_BITS-1:0]                out_upper_face_addr,
  output logic                                out_out_of_range,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIM_BITS-1:0]                 cfg_data
);

  logic [DIM_BITS-1:0] cells_z_r;
  logic [DIM_BITS-1:0] cells_x_r;
  logic [DIM_BITS-1:0] cells_y_r;
  logic                q_valid;
  sgfa_pkg::item_t     q_item;
  logic                q_pop;

  assign cfg_ready = 1'b1;

  // Grid size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_z_r <= DIM_BITS'(1);
      cells_x_r <= DIM_BITS'(1);
      cells_y_r <= DIM_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sgfa_pkg::REG_CELLS_Z: cells_z_r <= cfg_data;
        sgfa_pkg::REG_CELLS_X: cells_x_r <= cfg_data;
        sgfa_pkg::REG_CELLS_Y: cells_y_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sgfa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_box_index (in_box_index),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  sgfa_back #(
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .cells_z             (cells_z_r),
    .cells_x             (cells_x_r),
    .cells_y             (cells_y_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_coord_k         (out_coord_k),
    .out_coord_i         (out_coord_i),
    .out_coord_j         (out_coord_j),
    .out_lower_face_addr (out_lower_face_addr),
    .out_upper_face_addr (out_upper_face_addr),
    .out_out_of_range    (out_out_of_range)
  );

endmodule

// File: rtl/sgfa_checker.sv
module sgfa_checker #(
  parameter int DIM_BITS  = 10,
  parameter int ADDR_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [DIM_BITS-1:0]  out_coord_k,
  input  logic [ADDR_BITS-1:0] out_lower_face_addr,
  input  logic [ADDR_BITS-1:0] out_upper_face_addr,
  input  logic                 out_out_of_range
);

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_lower_face_addr)
      && $stable(out_coord_k) && $stable(out_out_of_range))
    else $error("stalled result changed");

  // Without a flag the upper face sits right above the lower one, or both are zero
  a_upper_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      out_upper_face_addr == out_lower_face_addr + ADDR_BITS'(1) ||
      out_upper_face_addr == '0 && out_lower_face_addr == '0)
    else $error("upper face not lower plus one");

  // With a flag both faces are zero or both saturated
  a_flag_faces: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_upper_face_addr == out_lower_face_addr)
    else $error("flagged result has differing faces");

endmodule

bind staggered_grid_face_address sgfa_checker #(
  .DIM_BITS  (DIM_BITS),
  .ADDR_BITS (ADDR_BITS)
) u_sgfa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_coord_k         (out_coord_k),
  .out_lower_face_addr (out_lower_face_addr),
  .out_upper_face_addr (out_upper_face_addr),
  .out_out_of_range    (out_out_of_range)
);
